[hw/rtl/ssp_pkg.sv]
package ssp_pkg;

    localparam int SCREEN_WIDTH  = 640;
    localparam int SCREEN_HEIGHT = 480;
    localparam int HALF_W        = SCREEN_WIDTH / 2;
    localparam int HALF_H        = SCREEN_HEIGHT / 2;

    // divider geometry: quotient bits, numerator and divisor magnitudes
    localparam int QW = 17;
    localparam int NW = 45;
    localparam int DW = 40;

    // register stages: diff, products, sums, divider setup, QW steps, output
    localparam int NS = QW + 5;

    typedef struct packed {
        logic [DW-1:0] rem;
        logic [QW-1:0] low;
        logic [QW-1:0] q;
        logic [DW-1:0] den;
    } div_t;

    typedef struct packed {
        logic vis;
        logic csign;
        logic covf;
        logic sovf;
    } side_t;

endpackage

[hw/rtl/sprite_screen_projection_top.sv]
// Billboard sprite projection for a raycaster camera.
// Input channel (in_valid/in_ready): one beat is one sprite position, the
// viewer position and the camera direction and plane vectors.
// Output channel (out_valid/out_ready): one beat per input beat, in order:
// visibility, centre column, size and the clamped draw bounds. Fields are
// all zero when the sprite is not visible.
// The path from the input beat to output valid runs through 22 register
// stages: difference, products, sums, divider setup, 17 one-bit restoring
// division steps (two lanes in parallel, centre and size), and the
// bounds/output register.
// Throughput is one beat per cycle while out_ready stays high; each stage holds its own valid bit.
// When the receiver stalls, stages fill up behind the output register and
// bubbles are squeezed out; in_ready drops only once every stage is full.
// Nothing is lost or repeated across a stall.
// Reset (rst_n low, asynchronous) clears all valid bits; the pipeline comes
// up empty and ready.
module sprite_screen_projection_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] sprite_pos_x,
    input  logic signed [15:0] sprite_pos_y,
    input  logic signed [15:0] viewer_x,
    input  logic signed [15:0] viewer_y,
    input  logic signed [15:0] view_dir_x,
    input  logic signed [15:0] view_dir_y,
    input  logic signed [15:0] cam_plane_x,
    input  logic signed [15:0] cam_plane_y,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               visible,
    output logic signed [15:0] centre_column,
    output logic [11:0]        size_pixels,
    output logic [9:0]         first_column,
    output logic signed [12:0] last_column,
    output logic [9:0]         first_row,
    output logic [9:0]         last_row
);

    localparam int QW = ssp_pkg::QW;
    localparam int NW = ssp_pkg::NW;
    localparam int DW = ssp_pkg::DW;
    localparam int NS = ssp_pkg::NS;

    logic [NS-1:0] v_reg;
    logic [NS-1:0] en;

    // stage enables: a stage moves when empty or when its successor moves
    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || out_ready;
        for (int i = NS-2; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // stage 0: relative position, camera terms
    logic signed [16:0] sx_reg, sy_reg;
    logic signed [15:0] dx_reg, dy_reg, px_reg, py_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            sx_reg <= 17'(sprite_pos_x) - 17'(viewer_x);
            sy_reg <= 17'(sprite_pos_y) - 17'(viewer_y);
            dx_reg <= view_dir_x;
            dy_reg <= view_dir_y;
            px_reg <= cam_plane_x;
            py_reg <= cam_plane_y;
        end
    end

    // stage 1: products
    logic signed [32:0] dysx_reg, dxsy_reg, pxsy_reg, pysx_reg;
    logic signed [31:0] pxdy_reg, dxpy_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            dysx_reg <= 33'(dy_reg) * 33'(sx_reg);
            dxsy_reg <= 33'(dx_reg) * 33'(sy_reg);
            pxsy_reg <= 33'(px_reg) * 33'(sy_reg);
            pysx_reg <= 33'(py_reg) * 33'(sx_reg);
            pxdy_reg <= 32'(px_reg) * 32'(dy_reg);
            dxpy_reg <= 32'(dx_reg) * 32'(py_reg);
        end
    end

    // stage 2: determinant and numerators
    logic signed [33:0] det_reg, nx_reg, ny_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            det_reg <= 34'(pxdy_reg) - 34'(dxpy_reg);
            nx_reg  <= 34'(dysx_reg) - 34'(dxsy_reg);
            ny_reg  <= 34'(pxsy_reg) - 34'(pysx_reg);
        end
    end

    // stage 3: visibility, magnitudes and divider setup
    ssp_pkg::div_t  dc_reg [QW+1];
    ssp_pkg::div_t  ds_reg [QW+1];
    ssp_pkg::side_t sd_reg [QW+1];

    logic               vis;
    logic signed [34:0] nsum;
    logic signed [46:0] cprod;
    logic signed [46:0] cabs;
    logic [NW-1:0]      cnum;
    logic signed [33:0] adet_s, any_s;
    logic [NW-1:0]      snum;
    logic [DW-1:0]      cden, sden;
    logic [NW-QW-1:0]   chi, shi;
    logic               covf, sovf;

    always_comb
    begin
        vis    = (det_reg != '0) && (ny_reg != '0) && (det_reg[33] == ny_reg[33]);
        nsum   = 35'(nx_reg) + 35'(ny_reg);
        cprod  = 47'(nsum) * $signed(47'(ssp_pkg::HALF_W));
        cabs   = cprod[46] ? -cprod : cprod;
        adet_s = det_reg[33] ? -det_reg : det_reg;
        any_s  = ny_reg[33] ? -ny_reg : ny_reg;
        cnum   = vis ? cabs[NW-1:0] : '0;
        snum   = vis ? NW'(45'(adet_s[32:0]) * 45'(ssp_pkg::SCREEN_HEIGHT)) : '0;
        cden   = vis ? DW'(any_s[32:0]) : DW'(1);
        sden   = vis ? DW'({any_s[32:0], 6'b0}) : DW'(1);
        chi    = cnum[NW-1:QW];
        shi    = snum[NW-1:QW];
        covf   = DW'(chi) >= cden;
        sovf   = DW'(shi) >= sden;
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            dc_reg[0].rem <= covf ? '0 : DW'(chi);
            dc_reg[0].low <= cnum[QW-1:0];
            dc_reg[0].q   <= '0;
            dc_reg[0].den <= cden;
            ds_reg[0].rem <= sovf ? '0 : DW'(shi);
            ds_reg[0].low <= snum[QW-1:0];
            ds_reg[0].q   <= '0;
            ds_reg[0].den <= sden;
            sd_reg[0].vis   <= vis;
            sd_reg[0].csign <= nsum[34] ^ ny_reg[33];
            sd_reg[0].covf  <= covf;
            sd_reg[0].sovf  <= sovf;
        end
    end

    // stages 4..3+QW: division steps, both lanes
    for (genvar k = 0; k < QW; k++)
    begin : g_div
        ssp_pkg::div_t c_next, s_next;

        ssp_div_step u_cstep (.d_in(dc_reg[k]), .d_out(c_next));
        ssp_div_step u_sstep (.d_in(ds_reg[k]), .d_out(s_next));

        always_ff @(posedge clk)
        begin
            if (en[4+k])
            begin
                dc_reg[k+1] <= c_next;
                ds_reg[k+1] <= s_next;
                sd_reg[k+1] <= sd_reg[k];
            end
        end
    end

    // final stage: signed centre, size saturation, bounds clamping
    logic [QW-1:0]      cmag;
    logic signed [19:0] centre;
    logic [11:0]        size;
    logic signed [19:0] half;
    logic signed [19:0] col0, col1, row0, row1;
    ssp_pkg::side_t     sdf;

    logic               visible_next;
    logic signed [15:0] centre_next;
    logic [11:0]        size_next;
    logic [9:0]         col0_next, row0_next, row1_next;
    logic signed [12:0] col1_next;

    always_comb
    begin
        sdf    = sd_reg[QW];
        cmag   = sdf.covf ? '1 : dc_reg[QW].q;
        centre = sdf.csign ? -20'(cmag) : 20'(cmag);
        size   = (sdf.sovf || ds_reg[QW].q > QW'(4095)) ? 12'd4095
                                                          : ds_reg[QW].q[11:0];
        half   = 20'(size[11:1]);
        row0   = 20'(ssp_pkg::HALF_H) - half;
        row1   = 20'(ssp_pkg::HALF_H) + half;
        col0   = centre - half;
        col1   = centre + half;
        if (row0 < 0)
            row0 = '0;
        if (row1 >= 20'(ssp_pkg::SCREEN_HEIGHT))
            row1 = 20'(ssp_pkg::SCREEN_HEIGHT - 1);
        if (col0 < 0)
            col0 = '0;
        else if (col0 > 20'sd1023)
            col0 = 20'sd1023;
        if (col1 >= 20'(ssp_pkg::SCREEN_WIDTH))
            col1 = 20'(ssp_pkg::SCREEN_WIDTH - 1);
        if (col1 < -20'sd4096)
            col1 = -20'sd4096;

        visible_next = sdf.vis;
        if (centre > 20'sd32767)
            centre_next = 16'sh7fff;
        else if (centre < -20'sd32768)
            centre_next = -16'sh8000;
        else
            centre_next = centre[15:0];
        size_next = size;
        col0_next = col0[9:0];
        col1_next = col1[12:0];
        row0_next = row0[9:0];
        row1_next = row1[9:0];
        if (!sdf.vis)
        begin
            centre_next = '0;
            size_next   = '0;
            col0_next   = '0;
            col1_next   = '0;
            row0_next   = '0;
            row1_next   = '0;
        end
    end

    logic               visible_reg;
    logic signed [15:0] centre_reg;
    logic [11:0]        size_reg;
    logic [9:0]         col0_reg, row0_reg, row1_reg;
    logic signed [12:0] col1_reg;

    always_ff @(posedge clk)
    begin
        if (en[NS-1])
        begin
            visible_reg <= visible_next;
            centre_reg  <= centre_next;
            size_reg    <= size_next;
            col0_reg    <= col0_next;
            col1_reg    <= col1_next;
            row0_reg    <= row0_next;
            row1_reg    <= row1_next;
        end
    end

    assign visible       = visible_reg;
    assign centre_column = centre_reg;
    assign size_pixels   = size_reg;
    assign first_column  = col0_reg;
    assign last_column   = col1_reg;
    assign first_row     = row0_reg;
    assign last_row      = row1_reg;

endmodule

[hw/rtl/ssp_div_step.sv]
// one restoring division step: brings down one numerator bit
module ssp_div_step (
    input  ssp_pkg::div_t d_in,
    output ssp_pkg::div_t d_out
);

    logic [ssp_pkg::DW:0] trial;
    logic                 ge;
    logic [ssp_pkg::DW:0] diff;

    always_comb
    begin
        trial = {d_in.rem, d_in.low[ssp_pkg::QW-1]};
        ge    = trial >= {1'b0, d_in.den};
        diff  = trial - {1'b0, d_in.den};
        d_out.rem = ge ? diff[ssp_pkg::DW-1:0] : trial[ssp_pkg::DW-1:0];
        d_out.low = {d_in.low[ssp_pkg::QW-2:0], 1'b0};
        d_out.q   = {d_in.q[ssp_pkg::QW-2:0], ge};
        d_out.den = d_in.den;
    end

endmodule

[verif/sprite_projection_checker.sv]
module sprite_projection_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic signed [15:0] sprite_pos_x,
    input  logic signed [15:0] sprite_pos_y,
    input  logic signed [15:0] viewer_x,
    input  logic signed [15:0] viewer_y,
    input  logic signed [15:0] view_dir_x,
    input  logic signed [15:0] view_dir_y,
    input  logic signed [15:0] cam_plane_x,
    input  logic signed [15:0] cam_plane_y,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic               visible,
    input  logic signed [15:0] centre_column,
    input  logic [11:0]        size_pixels,
    input  logic [9:0]         first_column,
    input  logic signed [12:0] last_column,
    input  logic [9:0]         first_row,
    input  logic [9:0]         last_row,
    output int                 fail_count,
    output int                 pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic               vis;
        logic signed [15:0] centre;
        logic [11:0]        size;
        logic [9:0]         col0;
        logic signed [12:0] col1;
        logic [9:0]         row0;
        logic [9:0]         row1;
    } projection_t;

    projection_t expected_projections[$];

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // inverse camera transform, exact integer arithmetic truncated toward zero
    function automatic projection_t project_sprite(
        logic signed [15:0] spx, spy, vwx, vwy, dx, dy, px, py);
        longint sx, sy, det, nx, ny, centre, adet, any, size, half;
        longint r0, r1, c0, c1;
        projection_t p;
        p = '0;
        sx = longint'(spx) - longint'(vwx);
        sy = longint'(spy) - longint'(vwy);
        det = longint'(px) * dy - longint'(dx) * py;
        nx = longint'(dy) * sx - longint'(dx) * sy;
        ny = longint'(px) * sy - longint'(py) * sx;
        if (det == 0 || ny == 0 || ((det < 0) != (ny < 0)))
            return p;
        centre = (longint'(ssp_pkg::HALF_W) * (ny + nx)) / ny;
        adet = det < 0 ? -det : det;
        any = ny < 0 ? -ny : ny;
        size = (longint'(ssp_pkg::SCREEN_HEIGHT) * adet) / (64 * any);
        if (size > 4095) size = 4095;
        half = size / 2;
        r0 = clip(ssp_pkg::HALF_H - half, 0, 1023);
        r1 = ssp_pkg::HALF_H + half;
        if (r1 >= ssp_pkg::SCREEN_HEIGHT) r1 = ssp_pkg::SCREEN_HEIGHT - 1;
        c0 = clip(centre - half, 0, 1023);
        c1 = centre + half;
        if (c1 >= ssp_pkg::SCREEN_WIDTH) c1 = ssp_pkg::SCREEN_WIDTH - 1;
        c1 = clip(c1, -4096, 1023);
        p.vis = 1'b1;
        p.centre = 16'(clip(centre, -32768, 32767));
        p.size = 12'(size);
        p.col0 = 10'(c0);
        p.col1 = 13'(c1);
        p.row0 = 10'(r0);
        p.row1 = 10'(clip(r1, 0, 1023));
        return p;
    endfunction

    assign pending_count = expected_projections.size();

    // predict on input beat, compare on output beat
    always @(posedge clk) begin
        projection_t got;
        projection_t want;
        if (rst_n) begin
            if (in_valid && in_ready)
                expected_projections.push_back(project_sprite(sprite_pos_x, sprite_pos_y,
                    viewer_x, viewer_y, view_dir_x, view_dir_y, cam_plane_x, cam_plane_y));
            if (out_valid && out_ready) begin
                got = '{visible, centre_column, size_pixels, first_column, last_column,
                        first_row, last_row};
                if (expected_projections.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected output beat %h", got);
                end else begin
                    want = expected_projections.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: exp vis=%0d c=%0d s=%0d col=%0d..%0d row=%0d..%0d; got vis=%0d c=%0d s=%0d col=%0d..%0d row=%0d..%0d",
                                want.vis, want.centre, want.size, want.col0, want.col1,
                                want.row0, want.row1, got.vis, got.centre, got.size,
                                got.col0, got.col1, got.row0, got.row1);
                    end
                end
            end
        end
    end

    initial fail_count = 0;
endmodule

[verif/sprite_screen_projection_top_test.sv]
module sprite_screen_projection_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk, rst_n, in_valid, in_ready, out_valid, out_ready;
    logic signed [15:0] sprite_pos_x, sprite_pos_y, viewer_x, viewer_y;
    logic signed [15:0] view_dir_x, view_dir_y, cam_plane_x, cam_plane_y;
    logic visible;
    logic signed [15:0] centre_column;
    logic [11:0] size_pixels;
    logic [9:0] first_column, first_row, last_row;
    logic signed [12:0] last_column;
    int fail_count, pending_count;
    bit calm;

    sprite_screen_projection_top dut (.*);
    sprite_projection_checker checker_i (.*);

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #50ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // receiver stalls about 36% of cycles except during calm stretch
    initial begin
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            out_ready <= calm || ($urandom_range(99) >= 36);
        end
    end

    // drive one beat and hold it until accepted; valid stays up for the next call
    task automatic send_sprite(logic [15:0] a, b, c, d, e, f, g, h);
        while (!calm && $urandom_range(99) < 36) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        {sprite_pos_x, sprite_pos_y, viewer_x, viewer_y} <= {a, b, c, d};
        {view_dir_x, view_dir_y, cam_plane_x, cam_plane_y} <= {e, f, g, h};
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    function automatic logic [15:0] pick16();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(0, 8)) - 16'd4;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic signed [15:0] vx, vy, sx, sy;
        int n;
        rst_n = 1'b0; in_valid = 1'b0; calm = 1'b0;
        {sprite_pos_x, sprite_pos_y, viewer_x, viewer_y} = '0;
        {view_dir_x, view_dir_y, cam_plane_x, cam_plane_y} = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: straight ahead, behind, zero determinant, zero depth, extremes
        send_sprite(16'h0000, 16'h0500, 16'h0, 16'h0, 16'h0, 16'h4000, 16'h2a3d, 16'h0);
        send_sprite(16'h0000, -16'sh0500, 16'h0, 16'h0, 16'h0, 16'h4000, 16'h2a3d, 16'h0);
        send_sprite(16'h0100, 16'h0100, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
        send_sprite(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h4000, 16'h2a3d, 16'h0);
        send_sprite(16'h0001, 16'h0001, 16'h0, 16'h0, 16'h0, 16'h4000, 16'h2a3d, 16'h0);
        send_sprite(16'h7fff, 16'h0010, 16'h0, 16'h0, 16'h0, 16'h4000, 16'h2a3d, 16'h0);
        send_sprite(-16'sh7fff, 16'h0010, 16'h0, 16'h0, 16'h0, 16'h4000, 16'h2a3d, 16'h0);
        send_sprite(16'h0800, 16'h0400, 16'h0, 16'h0, 16'h0, 16'h4000, 16'h2a3d, 16'h0);
        send_sprite(-16'sh0800, 16'h0400, 16'h0, 16'h0, 16'h0, 16'h4000, 16'h2a3d, 16'h0);
        send_sprite(16'h7fff, 16'h7fff, 16'h8000, 16'h8000,
                    16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
        send_sprite(16'h8000, 16'h8000, 16'h7fff, 16'h7fff,
                    16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
        send_sprite(16'hffff, 16'hffff, 16'hffff, 16'hffff,
                    16'hffff, 16'hffff, 16'hffff, 16'hffff);
        send_sprite(16'h0100, 16'h0200, 16'h0000, 16'h0000,
                    16'h4000, 16'h0000, 16'h0000, -16'sh2a3d);

        // drain before random part
        in_valid <= 1'b0;
        while (pending_count != 0) @(negedge clk);

        for (n = 0; n < 650; n++) begin
            calm = (n >= 250 && n < 350);
            if (n == 450) begin
                in_valid <= 1'b0;
                while (pending_count != 0) @(negedge clk);
            end
            if ($urandom_range(9) < 7) begin
                // sensible camera, sprite near the viewer
                vx = 16'($urandom); vy = 16'($urandom);
                sx = vx + 16'($urandom_range(0, 4096)) - 16'sd2048;
                sy = vy + 16'($urandom_range(0, 4096)) - 16'sd2048;
                send_sprite(sx, sy, vx, vy,
                    16'($urandom_range(0, 32768)) - 16'sd16384,
                    16'($urandom_range(0, 32768)) - 16'sd16384,
                    16'($urandom_range(0, 16384)) - 16'sd8192,
                    16'($urandom_range(0, 16384)) - 16'sd8192);
            end else
                send_sprite(pick16(), pick16(), pick16(), pick16(),
                            pick16(), pick16(), pick16(), pick16());
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        while (pending_count != 0) @(negedge clk);
        repeat (40) @(negedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
